@@ design/script_tokenizer_defines.svh @@
// ----------------------------------------------------------------------------
// script tokenizer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKENIZER_DEFINES_SVH
`define SCRIPT_TOKENIZER_DEFINES_SVH

// same-cycle implication under reset
`define STK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define STK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/stk_pkg.sv @@
// ----------------------------------------------------------------------------
// stk_pkg
// types, constants and helpers shared by the script tokenizer
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int MAX_TOKEN_LEN = 256;
  localparam int LINE_BITS     = 20;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CHAR_W        = 16;
  localparam int LINE_OUT_W    = 20;
  localparam int RES_PER_ITEM  = 3;
  localparam int Q_DEPTH       = 4;
  localparam int Q_AW          = $clog2(Q_DEPTH);
  localparam int Q_CW          = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 16'h0028;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 16'h0029;
  localparam logic [CHAR_W-1:0] CH_STAR  = 16'h002A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;
  localparam logic [CHAR_W-1:0] CH_SLASH = 16'h002F;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 16'h003B;

  typedef enum logic [2:0] {
    MODE_BETWEEN,
    MODE_SLASH,
    MODE_LINE_CMT,
    MODE_BLOCK,
    MODE_BLOCK_STAR,
    MODE_TOKEN
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_END,
    KIND_CUT
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [CHAR_W-1:0]     token_char;
    logic [LINE_OUT_W-1:0] line_number;
    logic                  run_last;
  } result_t;

  typedef struct packed {
    logic                         valid;
    logic [1:0]                   cnt;
    result_t [RES_PER_ITEM-1:0]   res;
  } push_t;

  function automatic logic is_delim(input logic [CHAR_W-1:0] c);
    return (c == CH_QUOTE) || (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_SPACE) ||
           (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

@@ design/stk_if.sv @@
// ----------------------------------------------------------------------------
// stk_if
// valid/ready channels for input characters and tokenizer results
// ----------------------------------------------------------------------------
interface stk_in_if;
  import stk_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface stk_out_if;
  import stk_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [CHAR_W-1:0]     token_char;
  logic [LINE_OUT_W-1:0] line_number;
  logic                  run_last;

  modport source (output valid, output kind, output token_char, output line_number,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input token_char, input line_number,
                  input run_last, output ready);
endinterface

@@ design/stk_scan.sv @@
// ----------------------------------------------------------------------------
// stk_scan
// input register and scan state machine, turns one character into results
// ----------------------------------------------------------------------------
module stk_scan (
  input  logic           clk,
  input  logic           rst_n,
  stk_in_if.sink         in_ch,
  input  logic           room,
  output stk_pkg::push_t push
);
  import stk_pkg::*;

  logic                 in_valid_r;
  logic [CHAR_W-1:0]    in_char_r;
  logic                 in_eoi_r;
  logic                 adv;

  mode_t                mode_r, mode_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  assign adv         = in_valid_r && room;
  assign in_ch.ready = !in_valid_r || room;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char_r <= in_ch.char_code;
      in_eoi_r  <= in_ch.end_of_input;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      len_r  <= '0;
      line_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
    end
  end

  always_comb begin
    result_t [RES_PER_ITEM-1:0] res;
    logic [1:0]                 cnt;
    mode_nxt = mode_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    cnt      = 2'd0;
    for (int i = 0; i < RES_PER_ITEM; i++) begin
      res[i].kind        = KIND_CHAR;
      res[i].token_char  = '0;
      res[i].line_number = LINE_OUT_W'(line_r);
      res[i].run_last    = 1'b0;
    end
    if (adv) begin
      case (mode_r)
        MODE_SLASH: begin
          if (in_char_r == CH_SLASH) begin
            mode_nxt = MODE_LINE_CMT;
          end else if (in_char_r == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end else begin
            mode_nxt          = MODE_TOKEN;
            res[0].token_char = CH_SLASH;
            cnt               = 2'd2;
            if (is_delim(in_char_r)) begin
              res[1].kind = KIND_END;
              mode_nxt    = MODE_BETWEEN;
              len_nxt     = '0;
            end else begin
              res[1].token_char = in_char_r;
              len_nxt           = LEN_W'(2);
            end
          end
        end
        MODE_LINE_CMT: begin
          if (in_char_r == CH_LF) begin
            mode_nxt = MODE_BETWEEN;
          end
        end
        MODE_BLOCK: begin
          if (in_char_r == CH_STAR) begin
            mode_nxt = MODE_BLOCK_STAR;
          end
        end
        MODE_BLOCK_STAR: begin
          if (in_char_r == CH_SLASH) begin
            mode_nxt = MODE_BETWEEN;
          end else if (in_char_r != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
        MODE_TOKEN: begin
          if (is_delim(in_char_r)) begin
            res[0].kind = KIND_END;
            cnt         = 2'd1;
            mode_nxt    = MODE_BETWEEN;
            len_nxt     = '0;
          end else if (len_r >= LEN_W'(MAX_TOKEN_LEN)) begin
            res[0].kind       = KIND_CUT;
            res[1].token_char = in_char_r;
            cnt               = 2'd2;
            len_nxt           = LEN_W'(1);
          end else begin
            res[0].token_char = in_char_r;
            cnt               = 2'd1;
            len_nxt           = len_r + 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_BETWEEN;
          if (in_char_r <= CH_SPACE || in_char_r == CH_SEMI || in_char_r == CH_COMMA ||
              is_delim(in_char_r)) begin
            mode_nxt = MODE_BETWEEN;
          end else if (in_char_r == CH_SLASH && !in_eoi_r) begin
            mode_nxt = MODE_SLASH;
          end else begin
            mode_nxt          = MODE_TOKEN;
            res[0].token_char = in_char_r;
            cnt               = 2'd1;
            len_nxt           = LEN_W'(1);
          end
        end
      endcase
      if (in_eoi_r) begin
        if (mode_nxt == MODE_TOKEN) begin
          res[cnt].kind       = KIND_END;
          res[cnt].token_char = '0;
          cnt                 = cnt + 2'd1;
        end
        mode_nxt = MODE_BETWEEN;
        len_nxt  = '0;
      end
      if (in_char_r == CH_LF && line_r != {LINE_BITS{1'b1}}) begin
        line_nxt = line_r + 1'b1;
      end
      if (cnt != 2'd0) begin
        res[cnt - 2'd1].run_last = 1'b1;
      end
    end
    push.valid = adv;
    push.cnt   = cnt;
    push.res   = res;
  end

endmodule

@@ design/stk_outq.sv @@
// ----------------------------------------------------------------------------
// stk_outq
// small result queue, takes up to three results a cycle, sends one per beat
// ----------------------------------------------------------------------------
module stk_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  stk_pkg::push_t push,
  output logic          room,
  stk_out_if.source     out_ch
);
  import stk_pkg::*;

  result_t          mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]  count_r;
  logic [Q_CW-1:0]  count_nxt;
  logic             pop;
  logic [1:0]       n_push;
  result_t          head;

  assign pop    = (count_r != '0) && out_ch.ready;
  assign room   = (count_r - Q_CW'(pop)) <= Q_CW'(Q_DEPTH - RES_PER_ITEM);
  assign n_push = push.valid ? push.cnt : 2'd0;
  assign count_nxt = count_r - Q_CW'(pop) + Q_CW'(n_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_AW'(n_push);
      rd_ptr_r <= rd_ptr_r + Q_AW'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_PER_ITEM; i++) begin
      if (2'(i) < n_push) begin
        mem[wr_ptr_r + Q_AW'(i)] <= push.res[i];
      end
    end
  end

  assign head               = mem[rd_ptr_r];
  assign out_ch.valid       = (count_r != '0);
  assign out_ch.kind        = head.kind;
  assign out_ch.token_char  = head.token_char;
  assign out_ch.line_number = head.line_number;
  assign out_ch.run_last    = head.run_last;

endmodule

@@ design/script_tokenizer.sv @@
// ----------------------------------------------------------------------------
// script_tokenizer
// splits a 16-bit character stream into tokens, skipping c-style comments
// ----------------------------------------------------------------------------
// Characters enter one per beat through an input register; the scan state
// machine turns each into zero to three results (token character, end of
// token, or a cut at the length limit), which go into a four-entry queue
// and leave one per output beat. A new character is taken every cycle as long
// as the queue can hold three more results after this cycle's output beat,
// so the input runs at one character per cycle while each character yields
// at most one result; a character that yields two or three results holds the
// single output port until each of them has left. A character passes the
// input register and then the queue before its first result appears. The
// line count saturates and is kept across end of input.
module script_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  stk_in_if.sink    in_ch,
  stk_out_if.source out_ch
);
  import stk_pkg::*;

  push_t push;
  logic  room;

  stk_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  stk_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

@@ design/stk_checker.sv @@
// ----------------------------------------------------------------------------
// stk_checker
// port-level checks on the tokenizer result channel
// ----------------------------------------------------------------------------
`include "script_tokenizer_defines.svh"

module stk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_token_char,
  input logic [19:0] out_line_number,
  input logic        out_run_last
);
  import stk_pkg::*;

  // stalled beat holds
  `STK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_kind, out_token_char, out_line_number, out_run_last}), "result changed while stalled")

  // only token characters carry a character
  `STK_ASSERT_NOW(a_char_zero, out_valid && out_kind != KIND_CHAR, out_token_char == '0, "nonzero char on non-char result")

  // a cut is never the last result of its character; the character that caused it follows
  `STK_ASSERT_NOW(a_cut_not_last, out_valid && out_kind == KIND_CUT, !out_run_last, "cut marked as last result")

  // results of one character come without gaps
  `STK_ASSERT_NEXT(a_run_gapless, out_valid && !out_run_last, out_valid, "gap inside a character's results")

endmodule

bind script_tokenizer stk_checker u_stk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_token_char  (out_ch.token_char),
  .out_line_number (out_ch.line_number),
  .out_run_last    (out_ch.run_last)
);

@@ test/tb_script_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tb_script_tokenizer
// Feeds character streams into the tokenizer: short directed scripts for
// tokens, comments, slash handling, end of input and the length limit, then
// a few hundred characters of random script text mixed with noise. A local
// scanner predicts every result, and each output beat is checked field by
// field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_script_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import stk_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  stk_in_if  in_ch();
  stk_out_if out_ch();

  script_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // scanner state
  mode_t                 scan_st   = MODE_BETWEEN;
  int unsigned           tok_len   = 0;
  logic [LINE_BITS-1:0]  lines     = '0;
  logic [LINE_OUT_W-1:0] cur_line;
  result_t               token_q[$];

  int err_count = 0;
  bit idle_on   = 1'b1;
  bit stall_on  = 1'b1;
  result_t want;

  function automatic bit is_stop(input logic [CHAR_W-1:0] c);
    return c == CH_QUOTE || c == CH_LPAR || c == CH_RPAR || c == CH_SPACE ||
           c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic void push_result(input kind_t k, input logic [CHAR_W-1:0] ch);
    result_t r;
    r.kind        = k;
    r.token_char  = ch;
    r.line_number = cur_line;
    r.run_last    = 1'b0;
    token_q.push_back(r);
  endfunction

  function automatic void add_token_char(input logic [CHAR_W-1:0] c);
    if (tok_len >= MAX_TOKEN_LEN) begin
      push_result(KIND_CUT, '0);
      tok_len = 0;
    end
    push_result(KIND_CHAR, c);
    tok_len++;
  endfunction

  function automatic void token_step(input logic [CHAR_W-1:0] c);
    if (is_stop(c)) begin
      push_result(KIND_END, '0);
      scan_st = MODE_BETWEEN;
      tok_len = 0;
    end else begin
      add_token_char(c);
    end
  endfunction

  function automatic void scan_char(input logic [CHAR_W-1:0] c, input logic eoi);
    int first;
    bit skip;
    result_t r;
    first    = token_q.size();
    cur_line = lines[LINE_OUT_W-1:0];
    case (scan_st)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          scan_st = MODE_LINE_CMT;
        end else if (c == CH_STAR) begin
          scan_st = MODE_BLOCK;
        end else begin
          scan_st = MODE_TOKEN;
          tok_len = 0;
          add_token_char(CH_SLASH);
          token_step(c);
        end
      end
      MODE_LINE_CMT: begin
        if (c == CH_LF) scan_st = MODE_BETWEEN;
      end
      MODE_BLOCK: begin
        if (c == CH_STAR) scan_st = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (c == CH_SLASH) scan_st = MODE_BETWEEN;
        else if (c != CH_STAR) scan_st = MODE_BLOCK;
      end
      MODE_TOKEN: begin
        token_step(c);
      end
      default: begin
        scan_st = MODE_BETWEEN;
        skip = c <= CH_SPACE || c == CH_SEMI || c == CH_COMMA || is_stop(c);
        if (!skip) begin
          if (c == CH_SLASH && !eoi) begin
            scan_st = MODE_SLASH;
          end else begin
            scan_st = MODE_TOKEN;
            tok_len = 0;
            add_token_char(c);
          end
        end
      end
    endcase
    if (eoi) begin
      if (scan_st == MODE_TOKEN) push_result(KIND_END, '0);
      scan_st = MODE_BETWEEN;
      tok_len = 0;
    end
    if (c == CH_LF && lines != {LINE_BITS{1'b1}}) lines++;
    if (token_q.size() > first) begin
      r = token_q.pop_back();
      r.run_last = 1'b1;
      token_q.push_back(r);
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CHAR_W-1:0] stop_char();
    case ($urandom_range(0, 6))
      0: return CH_QUOTE;
      1: return CH_LPAR;
      2: return CH_RPAR;
      3: return CH_SPACE;
      4: return CH_TAB;
      5: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] skip_char();
    case ($urandom_range(0, 2))
      0: return CH_SEMI;
      1: return CH_COMMA;
      default: return 16'($urandom_range(0, 32));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] word_char(input bit first);
    logic [CHAR_W-1:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 16'($urandom);
      else c = 16'($urandom_range(16'h21, 16'h7E));
    end while (is_stop(c) || (first && (c <= CH_SPACE || c == CH_SEMI ||
               c == CH_COMMA || c == CH_SLASH)));
    return c;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eoi);
    int unsigned gap;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.char_code    <= c;
    in_ch.end_of_input <= eoi;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    scan_char(c, eoi);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++)
      send_char({8'h00, s[i]}, eoi_last && i == s.len() - 1);
  endtask

  task automatic test_tokens();
    send_text("ab cd\t(x)\"y\"\r\n", 1'b0);
    send_char(CH_SEMI, 1'b0);
    send_char(CH_COMMA, 1'b0);
    send_char(16'h0001, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(16'h0000, 1'b0);
    send_char(CH_SPACE, 1'b0);
  endtask

  task automatic test_comments();
    send_text("//a b\n/*x**y*/z /**/\n", 1'b0);
  endtask

  task automatic test_slash();
    send_text("/a /(/;", 1'b0);
    send_char(CH_SLASH, 1'b1);
    send_char(CH_SLASH, 1'b1);
    send_char(CH_SLASH, 1'b0);
    send_char(16'h0078, 1'b1);
  endtask

  task automatic test_end_of_input();
    send_text("ab", 1'b1);
    send_text("/*q", 1'b1);
    send_text("//", 1'b1);
    send_text("k", 1'b1);
    send_char(CH_SPACE, 1'b1);
    send_char(CH_LF, 1'b1);
    send_text("m", 1'b0);
    send_char(CH_LF, 1'b0);
  endtask

  task automatic test_length_limit();
    bit keep;
    keep    = idle_on;
    idle_on = 1'b0;
    for (int i = 0; i < MAX_TOKEN_LEN; i++) send_char(word_char(i == 0), 1'b0);
    send_char(word_char(1'b0), 1'b1);
    for (int i = 0; i < 2 * MAX_TOKEN_LEN + 90; i++) send_char(word_char(i == 0), 1'b0);
    send_char(CH_SPACE, 1'b0);
    idle_on = keep;
  endtask

  task automatic test_random_script();
    int unsigned n_sent, pick, len;
    logic [CHAR_W-1:0] c;
    n_sent = 0;
    while (n_sent < 300) begin
      if ($urandom_range(0, 9) == 0) idle_on = ~idle_on;
      if ($urandom_range(0, 9) == 0) stall_on = ~stall_on;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        if ($urandom_range(0, 39) == 0) len = $urandom_range(255, 270);
        else len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) send_char(word_char(i == 0), 1'b0);
        n_sent += len;
        if ($urandom_range(0, 3) != 0) begin
          send_char(stop_char(), 1'b0);
          n_sent++;
        end
      end else if (pick < 47) begin
        send_char(skip_char(), 1'b0);
        n_sent++;
      end else if (pick < 57) begin
        send_char(CH_SLASH, 1'b0);
        send_char(CH_SLASH, 1'b0);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          c = 16'($urandom);
          if (c == CH_LF) c = CH_STAR;
          send_char(c, 1'b0);
        end
        send_char(CH_LF, 1'b0);
        n_sent += 3 + len;
      end else if (pick < 67) begin
        send_char(CH_SLASH, 1'b0);
        send_char(CH_STAR, 1'b0);
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0: c = CH_STAR;
            1: c = CH_SLASH;
            2: c = CH_LF;
            default: c = 16'($urandom);
          endcase
          send_char(c, 1'b0);
        end
        send_char(CH_STAR, 1'b0);
        send_char(CH_SLASH, 1'b0);
        n_sent += 4 + len;
      end else if (pick < 75) begin
        send_char(CH_SLASH, 1'b0);
        case ($urandom_range(0, 2))
          0: c = word_char(1'b0);
          1: c = stop_char();
          default: c = skip_char();
        endcase
        send_char(c, $urandom_range(0, 4) == 0);
        n_sent += 2;
      end else if (pick < 83) begin
        c = $urandom_range(0, 1) ? word_char(1'b0) : 16'($urandom);
        send_char(c, 1'b1);
        n_sent++;
      end else begin
        c = $urandom_range(0, 1) ? 16'($urandom_range(0, 127)) : 16'($urandom);
        send_char(c, $urandom_range(0, 15) == 0);
        n_sent++;
      end
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // output side back-pressure
  initial begin
    int unsigned n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      n = stall_on ? idle_len() : 0;
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (token_q.size() == 0) begin
        $error("unexpected beat: kind %0d char %h line %0d", out_ch.kind,
               out_ch.token_char, out_ch.line_number);
        err_count++;
      end else begin
        want = token_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          err_count++;
        end
        if (out_ch.token_char !== want.token_char) begin
          $error("token_char: expected %h, got %h", want.token_char, out_ch.token_char);
          err_count++;
        end
        if (out_ch.line_number !== want.line_number) begin
          $error("line_number: expected %0d, got %0d", want.line_number,
                 out_ch.line_number);
          err_count++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, out_ch.run_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.char_code    = '0;
    in_ch.end_of_input = 1'b0;
    rst_n              = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_tokens();
    test_comments();
    test_slash();
    test_end_of_input();
    test_length_limit();
    test_random_script();
    in_ch.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
